[rtl/core/mdm_pkg.sv]
package mdm_pkg;

   localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

   localparam int unsigned STEPS = 32;
   localparam int unsigned CNT_W = $clog2(STEPS);

   localparam logic [31:0] INTAKE_CAP_RESET = 32'd327680;
   localparam logic [15:0] CLEAR_THRESHOLD_RESET = 16'd66;

   localparam logic REG_INTAKE_CAP = 1'b0;
   localparam logic REG_CLEAR_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [31:0] intake_cap;
      logic [15:0] clear_threshold;
   } mdm_cfg_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] result;
   } mdm_unit_rsp_type;

endpackage

[rtl/core/mdm_csr.sv]
module mdm_csr
   import mdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output mdm_cfg_type cfg
);

   logic [31:0] intake_cap_ff;
   logic [31:0] intake_cap_in;
   logic [15:0] threshold_ff;
   logic [15:0] threshold_in;
   logic        write_en;
   logic        reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      intake_cap_in = intake_cap_ff;
      threshold_in  = threshold_ff;
      if (write_en) begin
         case (reg_index)
            REG_INTAKE_CAP:      intake_cap_in = csr_pwdata;
            REG_CLEAR_THRESHOLD: threshold_in  = csr_pwdata[15:0];
            default:             intake_cap_in = intake_cap_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_INTAKE_CAP:      csr_prdata = intake_cap_ff;
         REG_CLEAR_THRESHOLD: csr_prdata = {16'h0000, threshold_ff};
         default:             csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intake_cap_ff <= INTAKE_CAP_RESET;
         threshold_ff  <= CLEAR_THRESHOLD_RESET;
      end else begin
         intake_cap_ff <= intake_cap_in;
         threshold_ff  <= threshold_in;
      end
   end

   assign cfg.intake_cap      = intake_cap_ff;
   assign cfg.clear_threshold = threshold_ff;

endmodule

[rtl/core/mdm_serial_mul.sv]
module mdm_serial_mul
   import mdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      op_a,
   input  logic [31:0]      op_b,
   output mdm_unit_rsp_type rsp
);

   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [31:0]      a_ff;
   logic [31:0]      a_in;
   logic [31:0]      b_ff;
   logic [31:0]      b_in;
   logic [63:0]      acc_ff;
   logic [63:0]      acc_in;
   logic [32:0]      part_sum;

   assign part_sum = {1'b0, acc_ff[63:32]} + (b_ff[0] ? {1'b0, a_ff} : 33'd0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = 64'd0;
      end else if (busy_ff) begin
         // add one multiplier bit, shift the product right
         acc_in = {part_sum, acc_ff[31:1]};
         b_in   = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = (acc_ff[63:48] != 16'h0000) ? QMAX : acc_ff[47:16];

endmodule

[rtl/core/mdm_serial_div.sv]
module mdm_serial_div
   import mdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      op_a,
   input  logic [31:0]      op_b,
   output mdm_unit_rsp_type rsp
);

   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [31:0]      b_ff;
   logic [31:0]      b_in;
   logic [31:0]      rem_ff;
   logic [31:0]      rem_in;
   logic [31:0]      shift_ff;
   logic [31:0]      shift_in;
   logic [31:0]      q_ff;
   logic [31:0]      q_in;
   logic             sat_ff;
   logic             sat_in;
   logic [32:0]      trial;
   logic             fits;
   logic             sat_start;

   assign trial     = {rem_ff, shift_ff[31]};
   assign fits      = trial >= {1'b0, b_ff};
   // quotient of (a << 16) / b overflows 32 bits exactly when a >= b << 16
   assign sat_start = (op_b[31:16] == 16'h0000) && (op_a >= {op_b[15:0], 16'h0000});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         b_in     = op_b;
         rem_in   = {16'h0000, op_a[31:16]};
         shift_in = {op_a[15:0], 16'h0000};
         q_in     = 32'd0;
         sat_in   = sat_start;
      end else if (busy_ff) begin
         rem_in   = fits ? 32'(trial - {1'b0, b_ff}) : trial[31:0];
         q_in     = {q_ff[30:0], fits};
         shift_in = {shift_ff[30:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      q_ff     <= q_in;
      sat_ff   <= sat_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = sat_ff ? QMAX : q_ff;

endmodule

[rtl/core/meal_insulin_delivery_metering.sv]
// Each transaction runs five serial operations (two on the bit-serial multiplier,
// three on the bit-serial divider), then updates the state and the output; no new
// request is taken before that, and the update waits while the last response is stalled.
// Reset: synchronous, active high; clears the metering state and reloads the registers.
module meal_insulin_delivery_metering
   import mdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_new_carbs,
   input  logic [31:0] req_requested_insulin_rate,
   input  logic [31:0] req_step_length,
   input  logic [31:0] req_stomach_solid,
   input  logic [31:0] req_stomach_liquid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_carb_rate,
   output logic [31:0] rsp_insulin_rate,
   output logic [31:0] rsp_meal_dose,
   output logic [31:0] rsp_store_at_meal_start,
   output logic        rsp_eating,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_DUE  = 3'd1;
   localparam logic [2:0] S_DIV_INS  = 3'd2;
   localparam logic [2:0] S_DIV_PEND = 3'd3;
   localparam logic [2:0] S_DIV_NEW  = 3'd4;
   localparam logic [2:0] S_MUL_EAT  = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   mdm_cfg_type      cfg;
   mdm_unit_rsp_type mul_rsp;
   mdm_unit_rsp_type div_rsp;

   logic [2:0]  state_ff;
   logic [2:0]  state_in;
   logic        go_ff;
   logic        go_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] carb_out_ff;
   logic [31:0] carb_out_in;

   logic [31:0] carbs_ff;
   logic [31:0] carbs_in;
   logic [31:0] dt_ff;
   logic [31:0] dt_in;
   logic [31:0] solid_ff;
   logic [31:0] solid_in;
   logic [31:0] liquid_ff;
   logic [31:0] liquid_in;
   logic [31:0] rate_sel_ff;
   logic [31:0] rate_sel_in;
   logic [31:0] total_ff;
   logic [31:0] total_in;
   logic [31:0] due_ff;
   logic [31:0] due_in;
   logic [31:0] ins_q_ff;
   logic [31:0] ins_q_in;
   logic [31:0] pend_rate_ff;
   logic [31:0] pend_rate_in;
   logic [31:0] cr_ff;
   logic [31:0] cr_in;
   logic [31:0] eaten_ff;
   logic [31:0] eaten_in;

   logic [31:0] backlog_ff;
   logic [31:0] backlog_in;
   logic [31:0] prev_rate_ff;
   logic [31:0] prev_rate_in;
   logic [31:0] pending_ff;
   logic [31:0] pending_in;
   logic [31:0] meal_total_ff;
   logic [31:0] meal_total_in;
   logic [31:0] meal_start_ff;
   logic [31:0] meal_start_in;
   logic        eating_ff;
   logic        eating_in;

   logic        mul_start;
   logic [31:0] mul_a;
   logic        div_start;
   logic [31:0] div_a;
   logic        finish_ok;
   logic [32:0] total_sum;
   logic        div_taken;
   logic [31:0] rest;
   logic [32:0] carb_sum;
   logic [32:0] carb_left;
   logic [32:0] meal_sum;
   logic [32:0] store_sum;
   logic [31:0] cr_next;
   logic [31:0] new_rate;

   mdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign mul_start = go_ff && ((state_ff == S_MUL_DUE) || (state_ff == S_MUL_EAT));
   assign mul_a     = (state_ff == S_MUL_EAT) ? cr_ff : rate_sel_ff;

   mdm_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (dt_ff),
      .rsp   (mul_rsp)
   );

   assign div_start = go_ff && ((state_ff == S_DIV_INS) || (state_ff == S_DIV_PEND) ||
                                (state_ff == S_DIV_NEW));

   always_comb begin
      case (state_ff)
         S_DIV_INS:  div_a = total_ff;
         S_DIV_PEND: div_a = pending_ff;
         default:    div_a = carbs_ff;
      endcase
   end

   mdm_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .op_a  (div_a),
      .op_b  (dt_ff),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign finish_ok = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign total_sum = {1'b0, backlog_ff} + {1'b0, req_requested_insulin_rate};
   assign div_taken = (dt_ff != 32'd0) && (total_ff < due_ff);
   assign rest      = (total_ff >= due_ff) ? (total_ff - due_ff) : 32'd0;
   assign carb_sum  = {1'b0, carbs_ff} + {1'b0, pending_ff};
   assign carb_left = (carb_sum >= {1'b0, eaten_ff}) ? (carb_sum - {1'b0, eaten_ff}) : 33'd0;
   assign meal_sum  = {1'b0, meal_total_ff} + {1'b0, eaten_ff};
   assign store_sum = {1'b0, solid_ff} + {1'b0, liquid_ff};
   assign new_rate  = div_rsp.result;

   always_comb begin
      if (dt_ff == 32'd0) begin
         cr_next = 32'd0;
      end else if ((pend_rate_ff >= cfg.intake_cap) ||
                   ((new_rate >= cfg.intake_cap) && (pending_ff == 32'd0))) begin
         cr_next = cfg.intake_cap;
      end else if ((carbs_ff != 32'd0) && (pending_ff == 32'd0)) begin
         cr_next = new_rate;
      end else begin
         cr_next = pend_rate_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      carb_out_in   = carb_out_ff;
      carbs_in      = carbs_ff;
      dt_in         = dt_ff;
      solid_in      = solid_ff;
      liquid_in     = liquid_ff;
      rate_sel_in   = rate_sel_ff;
      total_in      = total_ff;
      due_in        = due_ff;
      ins_q_in      = ins_q_ff;
      pend_rate_in  = pend_rate_ff;
      cr_in         = cr_ff;
      eaten_in      = eaten_ff;
      backlog_in    = backlog_ff;
      prev_rate_in  = prev_rate_ff;
      pending_in    = pending_ff;
      meal_total_in = meal_total_ff;
      meal_start_in = meal_start_ff;
      eating_in     = eating_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               carbs_in  = req_new_carbs;
               dt_in     = req_step_length;
               solid_in  = req_stomach_solid;
               liquid_in = req_stomach_liquid;
               // hold the previous rate while a backlog remains and it exceeds the requested rate
               if ((backlog_ff != 32'd0) && (prev_rate_ff > req_requested_insulin_rate)) begin
                  rate_sel_in = prev_rate_ff;
               end else begin
                  rate_sel_in = req_requested_insulin_rate;
               end
               total_in = total_sum[32] ? QMAX : total_sum[31:0];
               state_in = S_MUL_DUE;
               go_in    = 1'b1;
            end
         end
         S_MUL_DUE: begin
            if (mul_rsp.done) begin
               due_in   = mul_rsp.result;
               state_in = S_DIV_INS;
               go_in    = 1'b1;
            end
         end
         S_DIV_INS: begin
            if (div_rsp.done) begin
               ins_q_in = div_rsp.result;
               state_in = S_DIV_PEND;
               go_in    = 1'b1;
            end
         end
         S_DIV_PEND: begin
            if (div_rsp.done) begin
               pend_rate_in = div_rsp.result;
               state_in     = S_DIV_NEW;
               go_in        = 1'b1;
            end
         end
         S_DIV_NEW: begin
            if (div_rsp.done) begin
               cr_in    = cr_next;
               state_in = S_MUL_EAT;
               go_in    = 1'b1;
            end
         end
         S_MUL_EAT: begin
            if (mul_rsp.done) begin
               eaten_in = mul_rsp.result;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (finish_ok) begin
               if (div_taken) begin
                  backlog_in   = 32'd0;
                  prev_rate_in = ins_q_ff;
               end else begin
                  backlog_in   = (rest < {16'h0000, cfg.clear_threshold}) ? 32'd0 : rest;
                  prev_rate_in = rate_sel_ff;
               end
               pending_in = carb_left[32] ? QMAX : carb_left[31:0];
               if (eating_ff) begin
                  meal_total_in = meal_sum[32] ? QMAX : meal_sum[31:0];
               end else if (cr_ff != 32'd0) begin
                  meal_total_in = eaten_ff;
               end
               if ((cr_ff != 32'd0) && !eating_ff) begin
                  eating_in     = 1'b1;
                  meal_start_in = store_sum[32] ? QMAX : store_sum[31:0];
               end else if ((cr_ff == 32'd0) && eating_ff) begin
                  eating_in = 1'b0;
               end
               carb_out_in  = cr_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         go_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         backlog_ff    <= 32'd0;
         prev_rate_ff  <= 32'd0;
         pending_ff    <= 32'd0;
         meal_total_ff <= 32'd0;
         meal_start_ff <= 32'd0;
         eating_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         rsp_valid_ff  <= rsp_valid_in;
         backlog_ff    <= backlog_in;
         prev_rate_ff  <= prev_rate_in;
         pending_ff    <= pending_in;
         meal_total_ff <= meal_total_in;
         meal_start_ff <= meal_start_in;
         eating_ff     <= eating_in;
      end
   end

   always_ff @(posedge clock) begin
      carb_out_ff  <= carb_out_in;
      carbs_ff     <= carbs_in;
      dt_ff        <= dt_in;
      solid_ff     <= solid_in;
      liquid_ff    <= liquid_in;
      rate_sel_ff  <= rate_sel_in;
      total_ff     <= total_in;
      due_ff       <= due_in;
      ins_q_ff     <= ins_q_in;
      pend_rate_ff <= pend_rate_in;
      cr_ff        <= cr_in;
      eaten_ff     <= eaten_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_carb_rate           = carb_out_ff;
   assign rsp_insulin_rate        = prev_rate_ff;
   assign rsp_meal_dose           = meal_total_ff;
   assign rsp_store_at_meal_start = meal_start_ff;
   assign rsp_eating              = eating_ff;

   // hold the finished step while the previous transaction still waits
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == S_FINISH))
      else $error("finished step left before the pending response was taken");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.busy && div_rsp.busy))
      else $error("multiplier and divider busy together");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_INS || state_ff == S_DIV_PEND ||
                        state_ff == S_DIV_NEW))
      else $error("divider finished outside a divide step");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_MUL_DUE || state_ff == S_MUL_EAT))
      else $error("multiplier finished outside a multiply step");

endmodule
